// ----- sv/linear_scan_priority_queue_top_defines.svh -----
// assertion macros for the linear scan priority queue
// used by linear_scan_priority_queue_top; expects i_clk and i_rst_n in scope
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on every rising edge outside reset
`define LSQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// checked on every rising edge, reset included
`define LSQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LSQ_ASSERT(label, prop, msg)
`define LSQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- sv/lsq_pkg.sv -----
// shared types and constants for the linear scan priority queue
// no dependencies
`timescale 1ns / 1ps

package lsq_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_INSERTED    = 2'd0;
    localparam logic [1:0] STATUS_REMOVED     = 2'd1;
    localparam logic [1:0] STATUS_REJ_FULL    = 2'd2;
    localparam logic [1:0] STATUS_REJ_EMPTY   = 2'd3;

    localparam logic [DATA_W-1:0] VALUE_NONE = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_DONE
    } t_state;

    // control from the sequencer to the best-entry tracker
    typedef struct packed {
        logic step;
        logic first;
    } t_scan_ctl;

endpackage

// ----- sv/lsq_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module lsq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lsq_best.sv -----
// best-entry tracker: one shared signed priority compare used once per scan cycle
// depends on lsq_pkg
`timescale 1ns / 1ps

module lsq_best
    import lsq_pkg::*;
#(
    parameter int AW = 4
) (
    input  logic                     i_clk,
    input  t_scan_ctl                i_ctl,
    input  logic [AW-1:0]            i_idx,
    input  logic signed [DATA_W-1:0] i_pri,
    input  logic signed [DATA_W-1:0] i_val,
    output logic [AW-1:0]            o_best_idx,
    output logic signed [DATA_W-1:0] o_best_val
);

    logic [AW-1:0]            r_best_idx;
    logic signed [DATA_W-1:0] r_best_pri;
    logic signed [DATA_W-1:0] r_best_val;
    logic                     take;

    // strictly smaller wins, so ties keep the lower index
    assign take = i_ctl.first || (i_pri < r_best_pri);

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && take) begin
            r_best_idx <= i_idx;
            r_best_pri <= i_pri;
            r_best_val <= i_val;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_best_val = r_best_val;

endmodule

// ----- sv/linear_scan_priority_queue_top.sv -----
// Bounded priority queue kept as an unsorted table in one ram of value/priority pairs.
// An insert is accepted together with its ram write, then the DONE state loads the output register.
// A remove of a non-empty table scans the live entries: the scan reads one stored
// priority per cycle through the ram's single read port into the shared signed compare,
// then the MOVE state moves the last entry into the freed slot. A reject goes straight to DONE.
// The block stalls its input from accept until the result is in the output register;
// a result beat may then wait on i_stall while the next item is accepted.
// depends on lsq_pkg, lsq_ram, lsq_best and linear_scan_priority_queue_top_defines.svh
`timescale 1ns / 1ps
`include "linear_scan_priority_queue_top_defines.svh"

module linear_scan_priority_queue_top
    import lsq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_operation,
    input  logic signed [DATA_W-1:0] i_item_value,
    input  logic signed [DATA_W-1:0] i_item_priority,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_entry_count,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (AW > CNT_W) ? AW : CNT_W;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cap;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [AW-1:0]          r_idx, n_idx;
    logic [2*DATA_W-1:0]    r_last, n_last;
    logic [DATA_W-1:0]      r_res_value, n_res_value;
    logic [1:0]             r_res_status, n_res_status;
    logic                   r_o_valid;
    logic [DATA_W-1:0]      r_o_value;
    logic [1:0]             r_o_status;
    logic [CNT_W-1:0]       r_o_count;
    logic                   r_o_empty;
    logic                   r_o_full;

    logic                   in_acc;
    logic                   out_load;
    logic [CNT_W-1:0]       eff_cap;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [2*DATA_W-1:0]    ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [2*DATA_W-1:0]    ram_rdata;
    t_scan_ctl              scan_ctl;
    logic [AW-1:0]          best_idx;
    logic signed [DATA_W-1:0] best_val;
    logic                   scan_last;
    logic                   best_live;

    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);

    // clamp the capacity register to 1 .. DEPTH
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (32'(r_cap) > 32'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = r_cap;
        end
    end

    // last live entry reaches the compare this cycle
    assign scan_last = (XW'(r_idx) == (XW'(r_count) - XW'(1)));

    // best entry lies among the live entries
    assign best_live = (XW'(best_idx) < XW'(r_count));

    // entry storage: value in the upper half, priority in the lower
    lsq_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared compare over the scanned entries
    lsq_best #(
        .AW (AW)
    ) u_best (
        .i_clk      (i_clk),
        .i_ctl      (scan_ctl),
        .i_idx      (r_idx),
        .i_pri      (ram_rdata[DATA_W-1:0]),
        .i_val      (ram_rdata[2*DATA_W-1:DATA_W]),
        .o_best_idx (best_idx),
        .o_best_val (best_val)
    );

    // sequencer: next state, ram control and result preparation
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_last       = r_last;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        ram_we       = 1'b0;
        ram_waddr    = AW'(r_count);
        ram_wdata    = {i_item_value, i_item_priority};
        ram_raddr    = '0;
        scan_ctl     = '0;
        out_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res_value = VALUE_NONE;
                    n_idx       = '0;
                    if (i_operation == OP_INSERT) begin
                        n_state = ST_DONE;
                        if (r_count >= eff_cap) begin
                            n_res_status = STATUS_REJ_FULL;
                        end else begin
                            ram_we       = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                            n_res_status = STATUS_INSERTED;
                        end
                    end else if (r_count == '0) begin
                        n_state      = ST_DONE;
                        n_res_status = STATUS_REJ_EMPTY;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                scan_ctl.step  = 1'b1;
                scan_ctl.first = (r_idx == '0);
                ram_raddr      = r_idx + AW'(1);
                if (scan_last) begin
                    n_last  = ram_rdata;
                    n_state = ST_MOVE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_MOVE: begin
                ram_we       = 1'b1;
                ram_waddr    = best_idx;
                ram_wdata    = r_last;
                n_count      = r_count - CNT_W'(1);
                n_res_value  = best_val;
                n_res_status = STATUS_REMOVED;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cap     <= CAP_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_last       <= n_last;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_o_value  <= r_res_value;
            r_o_status <= r_res_status;
            r_o_count  <= r_count;
            r_o_empty  <= (r_count == '0);
            r_o_full   <= (r_count >= eff_cap);
        end
    end

    assign o_valid         = r_o_valid;
    assign o_removed_value = r_o_value;
    assign o_status        = r_o_status;
    assign o_entry_count   = r_o_count;
    assign o_is_empty      = r_o_empty;
    assign o_is_full       = r_o_full;

    // checks on the sequencer and table bookkeeping
    `LSQ_ASSERT(a_count_in_range, 32'(r_count) <= 32'(DEPTH), "live count beyond depth")
    `LSQ_ASSERT(a_best_in_table, (r_state == ST_MOVE) |-> best_live, "best index not live")
    `LSQ_ASSERT(a_accept_leaves_idle, in_acc |=> (r_state != ST_IDLE), "accept did not start")
    `LSQ_ASSERT(a_insert_not_empty, (o_valid && (o_status == STATUS_INSERTED)) |-> !o_is_empty, "empty")

endmodule

// ----- sim/linear_scan_priority_queue_tb.sv -----
// self-checking testbench for linear_scan_priority_queue_top: directed and random beats
// against a shadow of the priority table, under bursty input and patterned output stalls
// depends on lsq_pkg and linear_scan_priority_queue_top
`timescale 1ns / 1ps

module testbench;
    import lsq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PHASE_COUNT   = 11;
    localparam int PHASE_ITEMS   = 100;
    localparam int unsigned RUN_LIMIT = 400000;

    // one expected or observed result beat
    typedef struct {
        logic signed [DATA_W-1:0] removed;
        logic [1:0]               status;
        logic [CNT_W-1:0]         count;
        logic                     empty;
        logic                     full;
    } t_outcome;

    // shadow of the unsorted table and the capacity register, plus outstanding results
    class t_pq_shadow;
        logic signed [DATA_W-1:0] value_slot[QUEUE_DEPTH];
        logic signed [DATA_W-1:0] prio_slot[QUEUE_DEPTH];
        int unsigned              live;
        logic [CNT_W-1:0]         cap_limit;
        t_outcome                 awaited[$];
        int unsigned              mismatches;

        function new();
            live       = 0;
            cap_limit  = CAP_RESET;
            mismatches = 0;
        endfunction

        function void write_capacity(logic [CNT_W-1:0] v);
            cap_limit = v;
        endfunction

        // zero acts as one, anything past the table depth acts as the depth
        function int unsigned usable_capacity();
            int unsigned c;
            c = cap_limit;
            if (c < 1) c = 1;
            if (c > QUEUE_DEPTH) c = QUEUE_DEPTH;
            return c;
        endfunction

        function void take_request(logic op, logic signed [DATA_W-1:0] val,
                                   logic signed [DATA_W-1:0] pri);
            t_outcome    res;
            int unsigned cap;
            int unsigned best;
            cap         = usable_capacity();
            res.removed = VALUE_NONE;
            if (op == OP_INSERT) begin
                if (live >= cap) begin
                    res.status = STATUS_REJ_FULL;
                end else begin
                    value_slot[live] = val;
                    prio_slot[live]  = pri;
                    live++;
                    res.status = STATUS_INSERTED;
                end
            end else begin
                if (live == 0) begin
                    res.status = STATUS_REJ_EMPTY;
                end else begin
                    // smallest signed priority, first index wins a tie
                    best = 0;
                    for (int i = 1; i < live; i++) begin
                        if (prio_slot[i] < prio_slot[best]) best = i;
                    end
                    res.removed      = value_slot[best];
                    value_slot[best] = value_slot[live-1];
                    prio_slot[best]  = prio_slot[live-1];
                    live--;
                    res.status = STATUS_REMOVED;
                end
            end
            res.count = CNT_W'(live);
            res.empty = (live == 0);
            res.full  = (live >= cap);
            awaited.push_back(res);
        endfunction

        function void check_outcome(t_outcome got);
            t_outcome want;
            if (awaited.size() == 0) begin
                $error("result beat with nothing outstanding");
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.removed !== want.removed) begin
                $error("removed_value: expected %0d, got %0d", want.removed, got.removed);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.count !== want.count) begin
                $error("entry_count: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
            if (got.empty !== want.empty) begin
                $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
                mismatches++;
            end
            if (got.full !== want.full) begin
                $error("is_full: expected %0d, got %0d", want.full, got.full);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_cfg_we        = 1'b0;
    logic [CNT_W-1:0]         i_cfg_wdata     = '0;
    logic                     i_valid         = 1'b0;
    logic                     o_stall;
    logic                     i_operation     = OP_INSERT;
    logic signed [DATA_W-1:0] i_item_value    = '0;
    logic signed [DATA_W-1:0] i_item_priority = '0;
    logic                     o_valid;
    logic                     i_stall         = 1'b0;
    logic signed [DATA_W-1:0] o_removed_value;
    logic [1:0]               o_status;
    logic [CNT_W-1:0]         o_entry_count;
    logic                     o_is_empty;
    logic                     o_is_full;

    t_pq_shadow  queue_shadow;
    int unsigned cycle_count = 0;
    int          burst_left  = 0;
    int          stall_mode  = 0;
    int          stall_run   = 0;

    linear_scan_priority_queue_top #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full)
    );

    always #6 i_clk = ~i_clk;

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("linear_scan_priority_queue_top: mismatch");
            $finish;
        end
    end

    // receiver stall pattern: free running, sparse, dense and periodic stretches
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(40, 200);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= ((cycle_count % 5) < 2);
        endcase
    end

    // compare every accepted result beat
    always @(posedge i_clk) begin : watch_results
        t_outcome got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.removed = o_removed_value;
            got.status  = o_status;
            got.count   = o_entry_count;
            got.empty   = o_is_empty;
            got.full    = o_is_full;
            queue_shadow.check_outcome(got);
        end
    end

    // present one beat, hold it until accepted, then maybe pause between bursts
    task automatic send_item(logic op, logic signed [DATA_W-1:0] val,
                             logic signed [DATA_W-1:0] pri);
        int gap;
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_item_value    <= val;
        i_item_priority <= pri;
        do @(posedge i_clk); while (o_stall);
        queue_shadow.take_request(op, val, pri);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (queue_shadow.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        queue_shadow.write_capacity(v);
        i_cfg_we <= 1'b0;
    endtask

    // priorities mix full range, a narrow band around zero for ties, and the extremes
    function automatic logic signed [DATA_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7) - 4;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [CNT_W-1:0] phase_cap[PHASE_COUNT];
        int               phase_insert_pct[PHASE_COUNT];
        logic             op;
        phase_cap        = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd17, 5'd1, 5'd8, 5'd2, 5'd24,
                             5'd5, 5'd16};
        phase_insert_pct = '{75, 50, 35, 80, 50, 50, 70, 30, 60, 50, 40};
        queue_shadow = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats at the reset capacity
        send_item(OP_REMOVE, $urandom, $urandom);
        send_item(OP_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(OP_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(OP_INSERT, 0, 0);
        send_item(OP_INSERT, -1, -1);
        send_item(OP_INSERT, 11, 5);
        send_item(OP_INSERT, 22, 5);
        repeat (6) send_item(OP_REMOVE, $urandom, $urandom);
        send_item(OP_REMOVE, $urandom, $urandom);
        send_item(OP_INSERT, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_item(OP_INSERT, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_item(OP_REMOVE, $urandom, $urandom);
        send_item(OP_REMOVE, $urandom, $urandom);
        // three-way tie on priority
        send_item(OP_INSERT, 1, 7);
        send_item(OP_INSERT, 2, 7);
        send_item(OP_INSERT, 3, 7);
        repeat (3) send_item(OP_REMOVE, $urandom, $urandom);
        wait_idle();

        // random phases, the table carries over so capacity can drop below the count
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_capacity(phase_cap[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(0, 99) < phase_insert_pct[p]) ? OP_INSERT : OP_REMOVE;
                send_item(op, $urandom, pick_priority());
            end
            wait_idle();
        end

        // settle for longer than the slowest remove
        repeat (24) @(posedge i_clk);
        if (queue_shadow.mismatches == 0 && queue_shadow.outstanding() == 0) begin
            $display("linear_scan_priority_queue_top: match");
        end else begin
            $display("linear_scan_priority_queue_top: mismatch");
        end
        $finish;
    end

endmodule
